// ----- design/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
// Holds the configuration record, the event codes and the register map.
// No dependencies.
package bcc_pkg;

    typedef struct packed {
        logic [15:0] short_min;
        logic [15:0] long_min;
        logic [15:0] long_max;
        logic [15:0] gap_min;
        logic [15:0] settle_ticks;
        logic        hold_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        CODE_SHORT  = 2'd0,
        CODE_DOUBLE = 2'd1,
        CODE_LONG   = 2'd2,
        CODE_HELD   = 2'd3
    } code_t;

    typedef enum logic [2:0] {
        REG_SHORT_MIN    = 3'd0,
        REG_LONG_MIN     = 3'd1,
        REG_LONG_MAX     = 3'd2,
        REG_GAP_MIN      = 3'd3,
        REG_SETTLE_TICKS = 3'd4,
        REG_HOLD_MODE    = 3'd5
    } reg_idx_t;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [15:0] SHORT_MIN_RST    = 16'd10;
    localparam logic [15:0] LONG_MIN_RST     = 16'd160;
    localparam logic [15:0] LONG_MAX_RST     = 16'd240;
    localparam logic [15:0] GAP_MIN_RST      = 16'd4;
    localparam logic [15:0] SETTLE_TICKS_RST = 16'd60;
    localparam logic        HOLD_MODE_RST    = 1'b1;

    localparam logic [7:0] HIST_RELEASED = 8'h0F;
    localparam logic [7:0] HIST_PRESSED  = 8'hF0;

    localparam longint unsigned REL_LIMIT = 64'd65530;

endpackage

// ----- design/bcc_if.sv -----
// Valid/ready channel interfaces for the button click classifier.
// One interface for incoming ticks and one for classification results.
// No dependencies.
interface bcc_in_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic clear_busy;

    modport source (output valid, output pin_level, output clear_busy, input ready);
    modport sink (input valid, input pin_level, input clear_busy, output ready);
endinterface

interface bcc_out_if;
    logic       valid;
    logic       ready;
    logic       event_valid;
    logic [1:0] event_code;
    logic       busy_res;
    logic       pressed_now;

    modport source (
        output valid, output event_valid, output event_code,
        output busy_res, output pressed_now, input ready
    );
    modport sink (
        input valid, input event_valid, input event_code,
        input busy_res, input pressed_now, output ready
    );
endinterface

// ----- design/bcc_regs.sv -----
// APB configuration register file for the button click classifier.
// Depends on bcc_pkg for the register map, reset values and cfg_t.
module bcc_regs
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SHORT_MIN:    cfg_next.short_min    = pwdata[15:0];
                REG_LONG_MIN:     cfg_next.long_min     = pwdata[15:0];
                REG_LONG_MAX:     cfg_next.long_max     = pwdata[15:0];
                REG_GAP_MIN:      cfg_next.gap_min      = pwdata[15:0];
                REG_SETTLE_TICKS: cfg_next.settle_ticks = pwdata[15:0];
                REG_HOLD_MODE:    cfg_next.hold_mode    = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SHORT_MIN:    prdata = DATA_W'(cfg_reg.short_min);
            REG_LONG_MIN:     prdata = DATA_W'(cfg_reg.long_min);
            REG_LONG_MAX:     prdata = DATA_W'(cfg_reg.long_max);
            REG_GAP_MIN:      prdata = DATA_W'(cfg_reg.gap_min);
            REG_SETTLE_TICKS: prdata = DATA_W'(cfg_reg.settle_ticks);
            REG_HOLD_MODE:    prdata = DATA_W'(cfg_reg.hold_mode);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_min    <= SHORT_MIN_RST;
            cfg_reg.long_min     <= LONG_MIN_RST;
            cfg_reg.long_max     <= LONG_MAX_RST;
            cfg_reg.gap_min      <= GAP_MIN_RST;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
            cfg_reg.hold_mode    <= HOLD_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/button_click_classifier_core.sv -----
// Top level of the button click classifier: tick channel, result channel, APB port.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if and bcc_regs.
//
// The block takes one tick per clock cycle while the result channel keeps up, and returns
// exactly one result for every tick, in the cycle after the tick transfer; a tick is taken
// whenever the result register is empty or its result is being taken in the same cycle, so
// the sustained rate is one tick per cycle unless the result channel stalls; the counter
// update and threshold compares sit in the single classification stage. Configuration must
// be written through the APB port while no tick is in flight; the block does not enforce it.
module button_click_classifier_core
    import bcc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    bcc_in_if.sink            tick,
    bcc_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned     CMP_W     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam longint unsigned CNT_MAX_L = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned REL_CAP_L = (CNT_MAX_L < REL_LIMIT) ? CNT_MAX_L : REL_LIMIT;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = CNT_MAX_L[COUNT_BITS-1:0];
    localparam logic [COUNT_BITS-1:0] REL_CAP = REL_CAP_L[COUNT_BITS-1:0];
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    cfg_t cfg;

    logic [7:0]            hist_reg,     hist_next;
    logic                  released_reg, released_next;
    logic [COUNT_BITS-1:0] rel_reg,      rel_next;
    logic [COUNT_BITS-1:0] gap_reg,      gap_next;
    logic [COUNT_BITS-1:0] press_reg,    press_next;
    logic [COUNT_BITS-1:0] held_reg,     held_next;
    logic                  pending_reg,  pending_next;
    code_t                 code_reg,     code_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  fired_reg,    fired_next;
    logic                  pressed_reg,  pressed_next;

    logic             accept;
    logic [CMP_W-1:0] rel_x, gap_x, press_x, held_x;
    logic [CMP_W-1:0] short_x, lmin_x, lmax_x, gmin_x, settle_x;
    logic             long_ok;

    bcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    assign short_x  = CMP_W'(cfg.short_min);
    assign lmin_x   = CMP_W'(cfg.long_min);
    assign lmax_x   = CMP_W'(cfg.long_max);
    assign gmin_x   = CMP_W'(cfg.gap_min);
    assign settle_x = CMP_W'(cfg.settle_ticks);

    always_comb
    begin
        pending_next  = pending_reg && !tick.clear_busy;
        hist_next     = {hist_reg[6:0], tick.pin_level};
        released_next = released_reg;
        rel_next      = rel_reg;
        gap_next      = gap_reg;
        press_next    = press_reg;
        held_next     = held_reg;
        code_next     = code_reg;
        fired_next    = 1'b0;

        if (hist_next == HIST_RELEASED)
        begin
            released_next = 1'b1;
            gap_next      = rel_reg;
            rel_next      = '0;
        end
        else if (hist_next == HIST_PRESSED)
        begin
            released_next = 1'b0;
        end

        if (released_next)
        begin
            rel_next = (rel_next >= REL_CAP) ? REL_CAP : rel_next + CNT_ONE;
        end
        else
        begin
            press_next = (press_reg == CNT_MAX) ? CNT_MAX : press_reg + CNT_ONE;
            held_next  = (held_reg == CNT_MAX) ? CNT_MAX : held_reg + CNT_ONE;
        end

        rel_x   = CMP_W'(rel_next);
        gap_x   = CMP_W'(gap_next);
        press_x = CMP_W'(press_next);
        held_x  = CMP_W'(held_next);
        long_ok = (press_x > lmin_x) && (!cfg.hold_mode || press_x < lmax_x);

        if (!pending_next)
        begin
            if (rel_x == settle_x)
            begin
                if (gap_x > gmin_x && gap_x < settle_x)
                begin
                    code_next  = CODE_DOUBLE;
                    fired_next = 1'b1;
                end
                else if (press_x > short_x && press_x < lmin_x)
                begin
                    code_next  = CODE_SHORT;
                    fired_next = 1'b1;
                end
                else if (long_ok)
                begin
                    code_next  = CODE_LONG;
                    fired_next = 1'b1;
                end
                gap_next   = '0;
                press_next = '0;
                held_next  = '0;
            end
            else if (cfg.hold_mode && held_x > lmax_x)
            begin
                code_next  = CODE_HELD;
                fired_next = 1'b1;
                held_next  = '0;
            end
        end

        if (fired_next)
        begin
            pending_next = 1'b1;
        end

        pressed_next = !tick.pin_level;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            released_reg  <= 1'b0;
            rel_reg       <= '0;
            gap_reg       <= '0;
            press_reg     <= '0;
            held_reg      <= '0;
            pending_reg   <= 1'b0;
            code_reg      <= CODE_SHORT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                hist_reg     <= hist_next;
                released_reg <= released_next;
                rel_reg      <= rel_next;
                gap_reg      <= gap_next;
                press_reg    <= press_next;
                held_reg     <= held_next;
                pending_reg  <= pending_next;
                code_reg     <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fired_reg   <= fired_next;
            pressed_reg <= pressed_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.event_valid = fired_reg;
    assign result.event_code  = code_reg;
    assign result.busy_res    = pending_reg;
    assign result.pressed_now = pressed_reg;

endmodule

// ----- design/bcc_checker.sv -----
// Port-level checker for the button click classifier, bound to its top level.
// Depends on the ports of button_click_classifier_core only.
module bcc_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic event_valid,
    input logic busy_res
);

    a_event_sets_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> busy_res
    ) else $error("An event result does not show busy.");

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid
    ) else $error("A tick transfer did not produce a result.");

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("Tick channel stalled with an empty result register.");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid
    ) else $error("A stalled result was dropped.");

endmodule

bind button_click_classifier_core bcc_port_checker u_bcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (tick.valid),
    .in_ready    (tick.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .event_valid (result.event_valid),
    .busy_res    (result.busy_res)
);

// ----- verif/bcc_checker.sv -----
// Checker for the button click classifier: watches the tick and result channels and the APB port.
// Predicts one result per tick transfer and compares each result transfer field by field.
// Depends on bcc_pkg, bcc_in_if and bcc_out_if.
module bcc_checker
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bcc_in_if                 tick,
    bcc_out_if                result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int unsigned       mismatches,
    output int unsigned       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic  event_valid;
        code_t code;
        logic  busy;
        logic  pressed;
    } click_result_t;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] REL_CAP   = 16'(REL_LIMIT);

    cfg_t          cfg;
    logic [7:0]    history;
    logic          is_released;
    logic [15:0]   rel_count;
    logic [15:0]   last_gap;
    logic [15:0]   press_count;
    logic [15:0]   hold_count;
    logic          event_pending;
    code_t         shown_code;
    click_result_t predicted_clicks[$];

    function automatic logic [15:0] step_sat(input logic [15:0] v, input logic [15:0] cap);
        return (v >= cap) ? cap : v + 16'd1;
    endfunction

    function automatic click_result_t classify_tick(input logic pin, input logic clr);
        click_result_t r;
        logic          fired;
        logic          long_fits;
        fired = 1'b0;
        if (clr)
        begin
            event_pending = 1'b0;
        end
        history = {history[6:0], pin};
        if (history == HIST_RELEASED)
        begin
            is_released = 1'b1;
            last_gap    = rel_count;
            rel_count   = '0;
        end
        else if (history == HIST_PRESSED)
        begin
            is_released = 1'b0;
        end
        if (is_released)
        begin
            rel_count = step_sat(rel_count, REL_CAP);
        end
        else
        begin
            press_count = step_sat(press_count, COUNT_MAX);
            hold_count  = step_sat(hold_count, COUNT_MAX);
        end
        if (!event_pending)
        begin
            if (rel_count == cfg.settle_ticks)
            begin
                long_fits = (press_count > cfg.long_min) &&
                            (!cfg.hold_mode || press_count < cfg.long_max);
                if (last_gap > cfg.gap_min && last_gap < cfg.settle_ticks)
                begin
                    shown_code = CODE_DOUBLE;
                    fired      = 1'b1;
                end
                else if (press_count > cfg.short_min && press_count < cfg.long_min)
                begin
                    shown_code = CODE_SHORT;
                    fired      = 1'b1;
                end
                else if (long_fits)
                begin
                    shown_code = CODE_LONG;
                    fired      = 1'b1;
                end
                last_gap    = '0;
                press_count = '0;
                hold_count  = '0;
            end
            else if (cfg.hold_mode && hold_count > cfg.long_max)
            begin
                shown_code = CODE_HELD;
                fired      = 1'b1;
                hold_count = '0;
            end
        end
        if (fired)
        begin
            event_pending = 1'b1;
        end
        r.event_valid = fired;
        r.code        = shown_code;
        r.busy        = event_pending;
        r.pressed     = ~pin;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        click_result_t want;
        if (!rst_n)
        begin
            cfg.short_min    = SHORT_MIN_RST;
            cfg.long_min     = LONG_MIN_RST;
            cfg.long_max     = LONG_MAX_RST;
            cfg.gap_min      = GAP_MIN_RST;
            cfg.settle_ticks = SETTLE_TICKS_RST;
            cfg.hold_mode    = HOLD_MODE_RST;
            history          = '0;
            is_released      = 1'b0;
            rel_count        = '0;
            last_gap         = '0;
            press_count      = '0;
            hold_count       = '0;
            event_pending    = 1'b0;
            shown_code       = CODE_SHORT;
            predicted_clicks.delete();
            mismatches       = 0;
            outstanding      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_SHORT_MIN:    cfg.short_min    = pwdata[15:0];
                    REG_LONG_MIN:     cfg.long_min     = pwdata[15:0];
                    REG_LONG_MAX:     cfg.long_max     = pwdata[15:0];
                    REG_GAP_MIN:      cfg.gap_min      = pwdata[15:0];
                    REG_SETTLE_TICKS: cfg.settle_ticks = pwdata[15:0];
                    REG_HOLD_MODE:    cfg.hold_mode    = pwdata[0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (predicted_clicks.size() == 0)
                begin
                    report_mismatch("result transfer with no tick awaiting its result");
                end
                else
                begin
                    want = predicted_clicks.pop_front();
                    if (result.event_valid !== want.event_valid)
                        report_mismatch($sformatf("event_valid got %b expected %b",
                            result.event_valid, want.event_valid));
                    if (result.event_code !== want.code)
                        report_mismatch($sformatf("event_code got %0d expected %s",
                            result.event_code, want.code.name()));
                    if (result.busy_res !== want.busy)
                        report_mismatch($sformatf("busy_res got %b expected %b",
                            result.busy_res, want.busy));
                    if (result.pressed_now !== want.pressed)
                        report_mismatch($sformatf("pressed_now got %b expected %b",
                            result.pressed_now, want.pressed));
                end
            end
            if (tick.valid && tick.ready)
            begin
                predicted_clicks.push_back(classify_tick(tick.pin_level, tick.clear_busy));
            end
            outstanding = predicted_clicks.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the button click classifier: clock, reset, APB writes and tick stimulus.
// Instantiates button_click_classifier_core beside bcc_checker, which does all comparison.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_checker and button_click_classifier_core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam logic [24:0] DIR_PINS       = 25'b0000111111_0000111111_01010;
    localparam logic [24:0] DIR_CLEAR      = 25'b0000000000_1000000000_00110;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int unsigned       mismatches;
    int unsigned       outstanding;
    int unsigned       ticks_sent;
    int unsigned       burst_left;
    int unsigned       holdoff_requests;
    int unsigned       holdoffs_served;
    int unsigned       cycles;

    bcc_in_if  tick_ch ();
    bcc_out_if result_ch ();

    button_click_classifier_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bcc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_ch),
        .result      (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        holdoffs_served = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holdoff_requests != holdoffs_served)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoffs_served++;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
                if ($urandom_range(0, 3) != 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge clk);
                end
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [15:0] value);
        logic [DATA_W-1:0] data;
        data       = $urandom();
        if (idx == REG_HOLD_MODE)
            data[0] = value[0];
        else
            data[15:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input int unsigned s_min, input int unsigned l_min,
                                input int unsigned l_max, input int unsigned g_min,
                                input int unsigned settle, input int unsigned hold);
        apb_write(REG_SHORT_MIN, 16'(s_min));
        apb_write(REG_LONG_MIN, 16'(l_min));
        apb_write(REG_LONG_MAX, 16'(l_max));
        apb_write(REG_GAP_MIN, 16'(g_min));
        apb_write(REG_SETTLE_TICKS, 16'(settle));
        apb_write(REG_HOLD_MODE, 16'(hold));
    endtask

    function automatic logic clear_draw();
        return ($urandom_range(0, 3) == 0);
    endfunction

    task automatic send_tick(input logic pin, input logic clr);
        if (burst_left == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(1, 40);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.pin_level  <= pin;
        tick_ch.clear_busy <= clr;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic send_level(input logic pin, input int unsigned count);
        repeat (count) send_tick(pin, clear_draw());
    endtask

    task automatic run_clicks(input int unsigned n_items, input int unsigned press_max,
                              input int unsigned gap_max);
        int unsigned first;
        first = ticks_sent;
        while (ticks_sent - first < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(0, 1)), clear_draw());
                end
                1:
                begin
                    send_level(1'b0, $urandom_range(press_max, 3 * press_max));
                    send_level(1'b1, $urandom_range(4, gap_max + 4));
                end
                2:
                begin
                    send_level(1'b0, $urandom_range(4, press_max));
                    send_level(1'b1, $urandom_range(1, 3));
                    send_level(1'b0, $urandom_range(4, press_max));
                    send_level(1'b1, $urandom_range(4, gap_max + 4));
                end
                default:
                begin
                    send_level(1'b0, $urandom_range(4, press_max));
                    send_level(1'b1, $urandom_range(4, gap_max + 4));
                end
            endcase
        end
    endtask

    task automatic finish_phase();
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned s_min;
        int unsigned l_min;
        int unsigned l_max;
        tick_ch.valid      <= 1'b0;
        tick_ch.pin_level  <= 1'b1;
        tick_ch.clear_busy <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        rst_n              <= 1'b0;
        ticks_sent         = 0;
        burst_left         = 0;
        holdoff_requests   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(0, 6, 20, 0, 3, 1);
        for (int i = 24; i >= 0; i--)
        begin
            send_tick(DIR_PINS[i], DIR_CLEAR[i]);
        end
        finish_phase();

        write_config(2, 12, 20, 1, 8, 1);
        run_clicks(150, 26, 12);
        holdoff_requests++;
        run_clicks(150, 26, 12);
        finish_phase();

        write_config(0, 5, 0, 0, 6, 0);
        run_clicks(250, 14, 9);
        finish_phase();

        write_config(65535, 65535, 65535, 65535, 65530, 1);
        run_clicks(100, 40, 20);
        finish_phase();

        write_config(0, 0, 3, 0, 0, 1);
        run_clicks(150, 10, 6);
        finish_phase();

        s_min = $urandom_range(0, 6);
        l_min = $urandom_range(s_min + 2, 20);
        l_max = $urandom_range(l_min, 30);
        write_config(s_min, l_min, l_max, $urandom_range(0, 4), $urandom_range(3, 12),
                     $urandom_range(0, 1));
        run_clicks(250, 34, 14);
        finish_phase();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
